FILE: design/pes_pkg.sv
// Shared types and constants of the pending event scheduler.
package pes_pkg;

  // Counts at or above this value are never picked while another slot qualifies
  localparam logic signed [31:0] NO_EVENT_LIMIT = 32'sd999999;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ADD_ABS = 3'd1,
    OP_ADD_REL = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_ACK     = 3'd4,
    OP_QUERY   = 3'd5
  } pes_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_READ,
    ST_WAIT
  } pes_state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic scan;
    logic rd_issue;
    logic load_out;
  } pes_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rescan;
    logic scan_done;
    logic out_free;
  } pes_sts_t;

endpackage

FILE: design/pending_event_scheduler.sv
// Top level of the pending event scheduler: stream ports around controller and datapath.
//
// Usage: each input item on the slave stream carries one operation in tuser (tick,
// add absolute, add relative, remove, acknowledge, query) and a slot plus a signed
// cycle amount in tdata. Every accepted item yields exactly one result item on the
// master stream: the slot due next, the 16-bit pending countdown, and the used mark
// and relative cycle count of the addressed slot.
// Sequence: tick, query and ignored ops pass from acceptance through execute, the
// addressed read and the result load; ops that touch the table add a scan that
// walks the slot memory one entry per cycle through its single read port, updating
// counts and tracking the earliest deadline. One item is in work at a time; the
// result register lets the next item be accepted while the last result waits.
// Reset clears all used marks, the countdown, the overrun and the active slot; slot
// counts read as zero until first written. If the receiver stalls, the result is
// held in its register, and a finished item waits for it before the block idles.
module pending_event_scheduler #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [2:0] slot, [34:3] cycle_amount, zero pad
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o    // [2:0] next_slot, [18:3] pending_count,
                                        // [19] slot_active, [51:20] cycles_passed, pad
);
  import pes_pkg::*;

  pes_cmd_t           cmd;
  pes_sts_t           sts;
  logic [2:0]         next_slot;
  logic signed [15:0] pending_count;
  logic               slot_active;
  logic signed [31:0] cycles_passed;

  // Sequence each item: execute, optional table scan, addressed read, result
  pes_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Slot table, deadline search and result register
  pes_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (s_axis_tuser_i),
    .slot_i          (s_axis_tdata_i[2:0]),
    .cycle_amount_i  (s_axis_tdata_i[34:3]),
    .out_ready_i     (m_axis_tready_i),
    .out_valid_o     (m_axis_tvalid_o),
    .next_slot_o     (next_slot),
    .pending_count_o (pending_count),
    .slot_active_o   (slot_active),
    .cycles_passed_o (cycles_passed)
  );

  // Pack result fields, lowest field first
  assign m_axis_tdata_o = {4'd0, cycles_passed, slot_active, pending_count, next_slot};

endmodule

FILE: design/pes_ctrl.sv
// Sequencing state machine of the pending event scheduler.
module pes_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pes_pkg::pes_sts_t sts_i,
  output pes_pkg::pes_cmd_t cmd_o
);
  import pes_pkg::*;

  pes_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = sts_i.rescan ? ST_SCAN : ST_READ;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_READ: begin
        cmd_o.rd_issue = 1'b1;
      end
      ST_WAIT: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: design/pes_dp.sv
// Datapath of the pending event scheduler: slot table, scan unit and result register.
module pes_dp #(
  parameter int NUM_SLOTS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pes_pkg::pes_cmd_t  cmd_i,
  output pes_pkg::pes_sts_t  sts_o,
  input  logic [2:0]         op_i,
  input  logic [2:0]         slot_i,
  input  logic signed [31:0] cycle_amount_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         next_slot_o,
  output logic signed [15:0] pending_count_o,
  output logic               slot_active_o,
  output logic signed [31:0] cycles_passed_o
);
  import pes_pkg::*;

  localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  // Slot table: counts in a memory, marks in flops
  logic [31:0]          mem [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] used_q;
  logic [NUM_SLOTS-1:0] wr_q;    // entry written since reset, else reads zero

  // Captured item
  pes_op_e     op_q;
  logic [2:0]  slot_q;
  logic [31:0] amt_q;
  logic        in_range_q;
  logic [SW-1:0] slot_idx;

  // Timer state
  logic [15:0]   countdown_q;
  logic [15:0]   overrun_q;
  logic [SW-1:0] act_q;
  logic [31:0]   act_cnt_q;      // mirror of the active slot's count

  // Scan state
  logic [CW-1:0] scan_cnt_q;
  logic          scan_vld_q;
  logic [SW-1:0] rd_idx_q;
  logic [31:0]   rd_data_q;
  logic          rd_wr_q;
  logic [31:0]   elapsed_q;
  logic          adv_q;
  logic          ack_q;
  logic [SW-1:0] best_idx_q, best_idx_d;
  logic [31:0]   best_cnt_q, best_cnt_d;
  logic          found_q, found_d;
  logic [31:0]   from_last_q;

  // Result register
  logic          out_valid_q;
  logic [2:0]    res_slot_q;
  logic [15:0]   res_count_q;
  logic          res_active_q;
  logic [31:0]   res_passed_q;

  // Memory port controls
  logic          we, re;
  logic [SW-1:0] wa, ra;
  logic [31:0]   wd;
  logic [31:0]   rd_val, scan_val, thr;
  logic          cand, scan_issue, scan_done;
  logic [31:0]   ovr_ext, cd_ext;

  assign slot_idx = SW'(slot_q);
  assign ovr_ext  = {{16{overrun_q[15]}}, overrun_q};
  assign cd_ext   = {{16{countdown_q[15]}}, countdown_q};
  assign rd_val   = rd_wr_q ? rd_data_q : 32'd0;
  // Only used slots advance; an unused slot keeps its stale count
  assign scan_val = used_q[rd_idx_q] ? (rd_val - elapsed_q) : rd_val;
  assign cand     = used_q[rd_idx_q] && !(ack_q && (rd_idx_q == act_q));
  assign thr      = found_q ? best_cnt_q : NO_EVENT_LIMIT;
  assign scan_issue = cmd_i.scan && (scan_cnt_q < CW'(NUM_SLOTS));
  assign scan_done  = cmd_i.scan && scan_vld_q && (rd_idx_q == SW'(NUM_SLOTS - 1));

  always_comb begin
    sts_o.rescan = ((op_q == OP_ADD_ABS || op_q == OP_ADD_REL || op_q == OP_REMOVE)
                    && in_range_q) || (op_q == OP_ACK);
    sts_o.scan_done = scan_done;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Running minimum; the first entry seeds it so an empty table falls to slot 0
  always_comb begin
    best_idx_d = best_idx_q;
    best_cnt_d = best_cnt_q;
    found_d    = found_q;
    if (scan_vld_q) begin
      if (rd_idx_q == '0) begin
        best_idx_d = '0;
        best_cnt_d = scan_val;
        found_d    = cand && ($signed(scan_val) < NO_EVENT_LIMIT);
      end else if (cand && ($signed(scan_val) < $signed(thr))) begin
        best_idx_d = rd_idx_q;
        best_cnt_d = scan_val;
        found_d    = 1'b1;
      end
    end
  end

  always_comb begin
    we = 1'b0;
    wa = slot_idx;
    wd = amt_q;
    re = 1'b0;
    ra = slot_idx;
    if (cmd_i.exec && in_range_q) begin
      if (op_q == OP_ADD_ABS) begin
        we = 1'b1;
        wd = amt_q + ovr_ext;
      end else if (op_q == OP_ADD_REL) begin
        we = 1'b1;
      end
    end
    if (cmd_i.scan && scan_vld_q && adv_q && used_q[rd_idx_q]) begin
      we = 1'b1;
      wa = rd_idx_q;
      wd = scan_val;
    end
    if (scan_issue) begin
      re = 1'b1;
      ra = scan_cnt_q[SW-1:0];
    end else if (cmd_i.rd_issue) begin
      re = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) begin
      rd_data_q <= mem[ra];
      rd_wr_q   <= wr_q[ra];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      slot_q     <= slot_i;
      amt_q      <= cycle_amount_i;
      in_range_q <= ({29'd0, slot_i} < 32'(NUM_SLOTS));
    end
    if (cmd_i.exec) begin
      elapsed_q <= ((op_q == OP_REMOVE && in_range_q) || op_q == OP_ACK)
                   ? (act_cnt_q - cd_ext) : 32'd0;
    end
    if (scan_issue) rd_idx_q <= scan_cnt_q[SW-1:0];
    best_idx_q <= best_idx_d;
    best_cnt_q <= best_cnt_d;
    if (cmd_i.rd_issue) from_last_q <= act_cnt_q - cd_ext;
    if (cmd_i.load_out) begin
      res_slot_q   <= 3'(act_q);
      res_count_q  <= countdown_q;
      res_active_q <= in_range_q ? used_q[slot_idx] : 1'b0;
      res_passed_q <= (in_range_q ? rd_val : 32'd0) - from_last_q;
    end
  end

  // Control and timer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q        <= OP_TICK;
      used_q      <= '0;
      wr_q        <= '0;
      countdown_q <= '0;
      overrun_q   <= '0;
      act_q       <= '0;
      act_cnt_q   <= '0;
      scan_cnt_q  <= '0;
      scan_vld_q  <= 1'b0;
      adv_q       <= 1'b0;
      ack_q       <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) op_q <= pes_op_e'(op_i);
      if (we) wr_q[wa] <= 1'b1;
      found_q    <= found_d;
      scan_vld_q <= scan_issue;
      if (scan_issue) scan_cnt_q <= scan_cnt_q + CW'(1);

      if (cmd_i.exec) begin
        scan_cnt_q <= '0;
        adv_q      <= (op_q == OP_ACK) || (op_q == OP_REMOVE && in_range_q);
        ack_q      <= (op_q == OP_ACK);
        case (op_q)
          OP_TICK: begin
            countdown_q <= countdown_q - amt_q[15:0];
          end
          OP_ADD_ABS, OP_ADD_REL: begin
            if (in_range_q) used_q[slot_idx] <= 1'b1;
          end
          OP_REMOVE: begin
            if (in_range_q) begin
              used_q[slot_idx] <= 1'b0;
              overrun_q        <= countdown_q;
            end
          end
          OP_ACK: begin
            overrun_q <= countdown_q;
          end
          default: ;
        endcase
      end

      // Load the winner and free the acknowledged slot
      if (scan_done) begin
        countdown_q <= best_cnt_d[15:0];
        act_q       <= best_idx_d;
        act_cnt_q   <= best_cnt_d;
        if (ack_q) used_q[act_q] <= 1'b0;
      end

      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign next_slot_o     = res_slot_q;
  assign pending_count_o = res_count_q;
  assign slot_active_o   = res_active_q;
  assign cycles_passed_o = res_passed_q;

endmodule

FILE: tb/pes_checker.sv
// Checker for the pending event scheduler: mirrors the slot table and compares every result item.
module pes_checker #(
  parameter int NUM_SLOTS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [39:0] s_data_i,     // [2:0] slot, [34:3] cycle_amount, zero pad
  input  logic [2:0]  s_user_i,     // [2:0] op
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [55:0] m_data_i,     // [2:0] next_slot, [18:3] pending_count,
                                    // [19] slot_active, [51:20] cycles_passed, pad
  output int          fail_count_o,
  output int          outstanding_o
);
  import pes_pkg::*;

  typedef struct packed {
    logic [2:0]  next_slot;
    logic [15:0] pending_count;
    logic        slot_active;
    logic [31:0] cycles_passed;
  } sched_status_t;

  // Mirror of the slot table and the countdown registers
  logic        tbl_used   [NUM_SLOTS];
  logic [31:0] tbl_cycles [NUM_SLOTS];
  logic [15:0] tbl_countdown;
  logic [15:0] tbl_overrun;
  logic [2:0]  tbl_active;

  sched_status_t status_q[$];
  sched_status_t want_r;
  sched_status_t got_r;
  int            fails;

  assign fail_count_o  = fails;
  assign outstanding_o = status_q.size();

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // Pick the earliest used slot below the limit; lower slot wins a tie
  function automatic void rescan_table();
    logic signed [31:0] best;
    logic [2:0]         pick;
    best = NO_EVENT_LIMIT;
    pick = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (tbl_used[k] && ($signed(tbl_cycles[k]) < best)) begin
        best = $signed(tbl_cycles[k]);
        pick = k[2:0];
      end
    end
    tbl_countdown = tbl_cycles[pick][15:0];
    tbl_active    = pick;
  endfunction

  // Move every used count forward by the time since the last event
  function automatic void advance_table();
    logic [31:0] elapsed;
    tbl_overrun = tbl_countdown;
    elapsed     = tbl_cycles[tbl_active] - sext16(tbl_overrun);
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (tbl_used[k]) tbl_cycles[k] = tbl_cycles[k] - elapsed;
    end
  endfunction

  function automatic sched_status_t apply_sched_op(input logic [2:0] op, input logic [2:0] slot,
                                                   input logic [31:0] amount);
    sched_status_t st;
    logic [31:0]   from_last;
    case (pes_op_e'(op))
      OP_TICK: tbl_countdown = tbl_countdown - amount[15:0];
      OP_ADD_ABS: begin
        tbl_used[slot]   = 1'b1;
        tbl_cycles[slot] = amount + sext16(tbl_overrun);
        rescan_table();
      end
      OP_ADD_REL: begin
        tbl_used[slot]   = 1'b1;
        tbl_cycles[slot] = amount;
        rescan_table();
      end
      OP_REMOVE: begin
        tbl_used[slot] = 1'b0;
        advance_table();
        rescan_table();
      end
      OP_ACK: begin
        advance_table();
        tbl_used[tbl_active] = 1'b0;
        rescan_table();
      end
      default: ;
    endcase
    from_last        = tbl_cycles[tbl_active] - sext16(tbl_countdown);
    st.next_slot     = tbl_active;
    st.pending_count = tbl_countdown;
    st.slot_active   = tbl_used[slot];
    st.cycles_passed = tbl_cycles[slot] - from_last;
    return st;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        tbl_used[k]   = 1'b0;
        tbl_cycles[k] = '0;
      end
      tbl_countdown = '0;
      tbl_overrun   = '0;
      tbl_active    = '0;
      status_q.delete();
    end else begin
      // Compare first: a result can never belong to the item accepted at this edge
      if (m_valid_i && m_ready_i) begin
        got_r = {m_data_i[2:0], m_data_i[18:3], m_data_i[19], m_data_i[51:20]};
        if (status_q.size() == 0) begin
          report_mismatch("result with no item in flight", m_data_i[31:0], '0);
        end else begin
          want_r = status_q.pop_front();
          if (got_r.next_slot !== want_r.next_slot)
            report_mismatch("next_slot", 32'(got_r.next_slot), 32'(want_r.next_slot));
          if (got_r.pending_count !== want_r.pending_count)
            report_mismatch("pending_count", 32'(got_r.pending_count),
                            32'(want_r.pending_count));
          if (got_r.slot_active !== want_r.slot_active)
            report_mismatch("slot_active", 32'(got_r.slot_active), 32'(want_r.slot_active));
          if (got_r.cycles_passed !== want_r.cycles_passed)
            report_mismatch("cycles_passed", got_r.cycles_passed, want_r.cycles_passed);
        end
      end
      if (s_valid_i && s_ready_i)
        status_q.push_back(apply_sched_op(s_user_i, s_data_i[2:0], s_data_i[34:3]));
    end
  end

endmodule

FILE: tb/tb_pending_event_scheduler.sv
// Testbench top for the pending event scheduler: clock, reset, stimulus and verdict.
module tb_pending_event_scheduler;
  import pes_pkg::*;

  localparam int NUM_SLOTS = 8;
  // Op codes the block does not decode; they must behave like query
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int RANDOM_ITEMS = 1900;
  // Last stretch of the run goes without idling on either side
  localparam int CALM_FROM = 1700;
  // Slowest item: an idle gap, a full table scan and a receiver stall; keep a wide margin
  localparam int STALL_LIMIT = 4000;
  // Settle time after the last result, above the longest op latency
  localparam int DRAIN_CYCLES = NUM_SLOTS + 20;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;   // [2:0] slot, [34:3] cycle_amount, zero pad
  logic [2:0]  s_axis_tuser_i;   // [2:0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [55:0] m_axis_tdata_o;   // [2:0] next_slot, [18:3] pending_count,
                                 // [19] slot_active, [51:20] cycles_passed, pad

  int fail_count;
  int outstanding;
  int quiet_cycles;
  bit idle_en;

  pending_event_scheduler #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  pes_checker #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_valid_i     (s_axis_tvalid_i),
    .s_ready_i     (s_axis_tready_o),
    .s_data_i      (s_axis_tdata_i),
    .s_user_i      (s_axis_tuser_i),
    .m_valid_i     (m_axis_tvalid_o),
    .m_ready_i     (m_axis_tready_i),
    .m_data_i      (m_axis_tdata_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  // Clock: 6 units high, 6 units low
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Receiver: stall in random bursts while idling is on
  initial begin
    int stall_left;
    m_axis_tready_i = 1'b0;
    stall_left      = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (idle_en && ($urandom_range(0, 4) == 0)) begin
        m_axis_tready_i <= 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves on either stream for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item, entered and left at a falling edge; idle a short burst first sometimes
  task automatic send_op(input logic [2:0] op, input logic [2:0] slot, input logic [31:0] amount);
    int gap;
    if (idle_en && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 3);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {5'b0, amount, slot};
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Delay values: mostly short, with sign flips, the no-event limit and full-range words
  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 3000);
      4:          return -$urandom_range(1, 3000);
      5:          return $urandom_range(999990, 1000010);
      6:          return $urandom;
      7:          return {$urandom_range(0, 1) ? 16'h7fff : 16'h8000, 16'($urandom)};
      8:          return $urandom_range(32700, 32800);
      default:    return $urandom_range(60000, 70000);
    endcase
  endfunction

  // Elapsed cycles for a tick: mostly a fraction of a typical countdown
  function automatic logic [31:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return $urandom;
      1:       return $urandom_range(0, 40000);
      default: return $urandom_range(0, 600);
    endcase
  endfunction

  // One random operation, weighted toward adds, ticks and acknowledges
  task automatic send_random_op();
    int          pick;
    logic [2:0]  slot;
    slot = 3'($urandom_range(0, NUM_SLOTS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 28)       send_op(OP_TICK, slot, pick_elapsed());
    else if (pick < 44)  send_op(OP_ADD_REL, slot, pick_delay());
    else if (pick < 58)  send_op(OP_ADD_ABS, slot, pick_delay());
    else if (pick < 68)  send_op(OP_REMOVE, slot, $urandom);
    else if (pick < 84)  send_op(OP_ACK, slot, $urandom);
    else if (pick < 96)  send_op(OP_QUERY, slot, $urandom);
    else                 send_op($urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, slot, $urandom);
  endtask

  initial begin
    int n;
    rst_ni          = 1'b0;
    idle_en         = 1'b1;
    quiet_cycles    = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tuser_i  = OP_QUERY;
    s_axis_tdata_i  = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, tick wrap, limit, ties, overrun, remove of the active slot
    send_op(OP_QUERY,   3'd0, 32'h0000_0000);
    send_op(OP_ACK,     3'd0, 32'h0000_0000);
    send_op(OP_TICK,    3'd0, 32'h7fff_ffff);
    send_op(OP_TICK,    3'd1, 32'h8000_0000);
    send_op(OP_TICK,    3'd2, 32'hffff_ffff);
    send_op(OP_ADD_REL, 3'd7, 32'h7fff_ffff);
    send_op(OP_ADD_ABS, 3'd3, 32'd999999);
    send_op(OP_ADD_ABS, 3'd4, 32'd999998);
    send_op(OP_ADD_REL, 3'd5, 32'd999998);
    send_op(OP_ADD_REL, 3'd2, 32'd500);
    send_op(OP_ADD_REL, 3'd6, 32'd500);
    send_op(OP_TICK,    3'd6, 32'd700);
    send_op(OP_ACK,     3'd6, 32'hffff_ffff);
    send_op(OP_ADD_ABS, 3'd1, 32'd100);
    send_op(OP_ADD_REL, 3'd0, 32'h8000_0000);
    send_op(OP_QUERY,   3'd7, 32'h0000_0000);
    send_op(OP_REMOVE,  3'd0, 32'h0000_0000);
    send_op(OP_REMOVE,  3'd2, 32'h0000_0000);
    send_op(OP_REMOVE,  3'd2, 32'h0000_0000);
    send_op(OP_SPARE_6, 3'd5, 32'h5555_5555);
    send_op(OP_SPARE_7, 3'd3, 32'haaaa_aaaa);
    send_op(OP_ACK,     3'd0, 32'h0000_0000);
    send_op(OP_ACK,     3'd0, 32'h0000_0000);
    send_op(OP_QUERY,   3'd4, 32'h0000_0000);

    // Random: alternate stretches with and without idling, then a calm finish
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      idle_en = (n < CALM_FROM) && (((n / 150) % 4) != 3);
      send_random_op();
    end
    s_axis_tvalid_i <= 1'b0;

    // Drain: wait for every result, then let the block settle
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/pes_pkg.sv
design/pes_ctrl.sv
design/pes_dp.sv
design/pending_event_scheduler.sv
tb/pes_checker.sv
tb/tb_pending_event_scheduler.sv
